// ===== hw/rtl/s8pf_pkg.sv =====
package s8pf_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 8'd1;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd170;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_HDR1,
        ST_HDR2,
        ST_ID,
        ST_LEN,
        ST_PAYLOAD,
        ST_SUM
    } state_t;

endpackage

// ===== hw/rtl/sum8_packet_framer_core.sv =====
// additive checksum packet framer
// input stream: one payload byte per transfer, s_tdata = {payload_byte, msg_id},
// s_tlast marks the last byte of a message. msg_id is taken from the first byte.
// bytes are kept in a single-port-write, registered-read payload memory while
// a running 8-bit sum of the payload is kept alongside.
// after the transfer with s_tlast, the frame comes out on the m_ side:
// header_first, header_second, id, length, payload bytes, checksum (m_tlast).
// m_tuser is the overflow flag, high on every byte of a frame that lost bytes
// beyond MAX_PAYLOAD; the length then saturates at MAX_PAYLOAD.
// the first frame byte is registered once the state has reached ST_HDR1, unless
// the previous checksum byte still waits in the output register. input takes
// one byte per cycle while collecting; a frame of n payload bytes goes out as
// n + 5 bytes, one byte a cycle from the output register while the receiver
// does not stall, with the memory read issued one byte ahead.
// s_tready is low from the last input transfer until the checksum byte is loaded.
// when the receiver stalls, the output register holds its byte and the
// sequencer waits; nothing is dropped.
// config writes (index 0: header_first, index 1: header_second) are always
// accepted; other indexes are ignored. reset restores both headers to 170,
// clears the byte count, id and overflow flag; the memory is not cleared.
module sum8_packet_framer_core #(
    parameter int unsigned MAX_PAYLOAD = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [7:0] msg_id, [15:8] payload_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // [7:0] frame_byte
    output logic        m_tlast,
    output logic        m_tuser   // [0] overflow
);
    import s8pf_pkg::*;

    localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);

    logic [BYTE_W-1:0] header_first_reg;
    logic [BYTE_W-1:0] header_second_reg;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= HEADER_RESET;
            header_second_reg <= HEADER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_HEADER_FIRST)
            begin
                header_first_reg <= cfg_data;
            end
            if (cfg_index == REG_HEADER_SECOND)
            begin
                header_second_reg <= cfg_data;
            end
        end
    end

    s8pf_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .header_first  (header_first_reg),
        .header_second (header_second_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .msg_id        (s_tdata[7:0]),
        .payload_byte  (s_tdata[15:8]),
        .is_last       (s_tlast),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .frame_byte    (m_tdata),
        .frame_end     (m_tlast),
        .overflow      (m_tuser),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    s8pf_payload_mem #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ===== hw/rtl/s8pf_payload_mem.sv =====
module s8pf_payload_mem #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [s8pf_pkg::BYTE_W-1:0] wr_data,
    input  logic [AW-1:0]             rd_addr,
    output logic [s8pf_pkg::BYTE_W-1:0] rd_data
);
    import s8pf_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // a write and a read of the same entry in one cycle return the new byte
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/s8pf_ctrl.sv =====
module s8pf_ctrl #(
    parameter int unsigned MAX_PAYLOAD = 32,
    parameter int unsigned AW          = 5,
    parameter int unsigned CW          = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [s8pf_pkg::BYTE_W-1:0] header_first,
    input  logic [s8pf_pkg::BYTE_W-1:0] header_second,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [s8pf_pkg::BYTE_W-1:0] msg_id,
    input  logic [s8pf_pkg::BYTE_W-1:0] payload_byte,
    input  logic                        is_last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [s8pf_pkg::BYTE_W-1:0] frame_byte,
    output logic                        frame_end,
    output logic                        overflow,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic [s8pf_pkg::BYTE_W-1:0] wr_data,
    output logic [AW-1:0]               rd_addr,
    input  logic [s8pf_pkg::BYTE_W-1:0] rd_data
);
    import s8pf_pkg::*;

    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_PAYLOAD);

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [BYTE_W-1:0] id_reg, id_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              dropped_reg, dropped_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_end_reg, out_end_next;
    logic              out_ovf_reg, out_ovf_next;

    logic              in_xfer;
    logic              load;
    logic [BYTE_W-1:0] checksum;
    logic [BYTE_W-1:0] length_byte;

    assign in_ready    = (state_reg == ST_COLLECT);
    assign in_xfer     = in_valid && in_ready;
    assign load        = (state_reg != ST_COLLECT) && (!out_valid_reg || out_ready);
    assign length_byte = BYTE_W'(count_reg);
    assign checksum    = header_first + header_second + id_reg + length_byte + sum_reg;

    assign wr_en   = in_xfer && (count_reg < MAX_COUNT);
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = payload_byte;
    assign rd_addr = rd_ptr_next[AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        id_next        = id_reg;
        sum_next       = sum_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;
        out_ovf_next   = out_ovf_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            out_end_next   = 1'b0;
            out_ovf_next   = dropped_reg;
        end

        unique case (state_reg)
            ST_COLLECT:
            begin
                rd_ptr_next = '0;
                if (in_xfer)
                begin
                    if (count_reg == '0)
                    begin
                        id_next = msg_id;
                    end
                    if (count_reg < MAX_COUNT)
                    begin
                        count_next = count_reg + 1'b1;
                        sum_next   = ((count_reg == '0) ? '0 : sum_reg) + payload_byte;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (is_last)
                    begin
                        state_next = ST_HDR1;
                    end
                end
            end
            ST_HDR1:
            begin
                out_byte_next = header_first;
                if (load)
                begin
                    state_next = ST_HDR2;
                end
            end
            ST_HDR2:
            begin
                out_byte_next = header_second;
                if (load)
                begin
                    state_next = ST_ID;
                end
            end
            ST_ID:
            begin
                out_byte_next = id_reg;
                if (load)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                out_byte_next = length_byte;
                if (load)
                begin
                    state_next = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                out_byte_next = rd_data;
                if (load)
                begin
                    if (rd_ptr_reg == CW'(count_reg - 1'b1))
                    begin
                        rd_ptr_next = '0;
                        state_next  = ST_SUM;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                    end
                end
            end
            ST_SUM:
            begin
                out_byte_next = checksum;
                if (load)
                begin
                    out_end_next = 1'b1;
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase

        if (!load)
        begin
            out_byte_next = out_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            id_reg        <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            id_reg        <= id_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign frame_end  = out_end_reg;
    assign overflow   = out_ovf_reg;

endmodule

// ===== hw/rtl/s8pf_checker.sv =====
module s8pf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // a stalled output byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // input closes only after a transfer that ends a message
    a_close_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tlast))
        else $error("input closed without a last transfer");

    // the checksum byte first shows up as collection reopens
    a_end_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid && m_tlast) |-> s_tready)
        else $error("frame end seen while input closed");

    // inside a frame bytes follow back to back with one overflow flag
    a_frame_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == $past(m_tuser)))
        else $error("frame broken or overflow flag changed");

endmodule

bind sum8_packet_framer_core s8pf_checker u_s8pf_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import s8pf_pkg::*;

    localparam int unsigned CAP           = 32;
    localparam int unsigned RAND_BYTES    = 160;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_WAIT      = 13;
    // index with no register behind it, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd7;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       overflow;
    } frame_beat_t;

    typedef enum logic { ROW_BYTE, ROW_CFG } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] a;          // msg_id, or register index
        logic [7:0] b;          // payload byte, or register value
        logic       last;
        logic       has_sum;
        logic [7:0] sum;
    } plan_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [7:0] msg_id, [15:8] payload_byte
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] frame_byte
    logic        m_tlast;
    logic        m_tuser;          // [0] overflow

    // framer model state
    logic [7:0]  hdr_first_q  = HEADER_RESET;
    logic [7:0]  hdr_second_q = HEADER_RESET;
    logic [7:0]  held_bytes [CAP];
    int unsigned held_count   = 0;
    logic [7:0]  held_id      = '0;
    logic        held_dropped = 1'b0;

    frame_beat_t pending_beats [$];
    int unsigned error_count = 0;
    logic        tx_idle_on  = 1'b1;
    logic        rx_idle_on  = 1'b1;

    plan_row_t   plan [0:18];

    always #6 clk = ~clk;

    sum8_packet_framer_core #(
        .MAX_PAYLOAD (CAP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // buffers one payload byte and, on the last one, queues the whole frame
    function automatic void frame_on_byte(input logic [7:0] id, input logic [7:0] data,
                                          input logic last, input logic has_sum,
                                          input logic [7:0] typed_sum);
        logic [7:0] acc;
        if (held_count == 0)
            held_id = id;
        if (held_count < CAP) begin
            held_bytes[held_count] = data;
            held_count++;
        end
        else
            held_dropped = 1'b1;
        if (!last)
            return;
        acc = hdr_first_q + hdr_second_q + held_id + 8'(held_count);
        for (int i = 0; i < held_count; i++)
            acc = acc + held_bytes[i];
        pending_beats.push_back('{hdr_first_q, 1'b0, held_dropped});
        pending_beats.push_back('{hdr_second_q, 1'b0, held_dropped});
        pending_beats.push_back('{held_id, 1'b0, held_dropped});
        pending_beats.push_back('{8'(held_count), 1'b0, held_dropped});
        for (int i = 0; i < held_count; i++)
            pending_beats.push_back('{held_bytes[i], 1'b0, held_dropped});
        pending_beats.push_back('{(has_sum ? typed_sum : acc), 1'b1, held_dropped});
        held_count   = 0;
        held_dropped = 1'b0;
    endfunction

    task automatic send_byte(input logic [7:0] id, input logic [7:0] data, input logic last,
                             input logic has_sum, input logic [7:0] typed_sum);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {data, id};
        s_tlast  <= last;
        do begin
            @(posedge clk);
        end while (!s_tready);
        frame_on_byte(id, data, last, has_sum, typed_sum);
    endtask

    task automatic wait_frames_out();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
        wait_frames_out();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_HEADER_FIRST)
            hdr_first_q = value;
        else if (idx == REG_HEADER_SECOND)
            hdr_second_q = value;
    endtask

    initial begin : stimulus
        int unsigned sent;
        int unsigned msg_no;
        int unsigned len;
        int unsigned pick;

        plan = '{
            // reset headers 170/170
            '{ROW_BYTE, 8'h00, 8'h00, 1'b1, 1'b1, 8'h55},
            '{ROW_BYTE, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'h53},
            '{ROW_CFG,  REG_HEADER_FIRST,  8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  REG_HEADER_SECOND, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, 8'h00, 8'h00, 1'b1, 1'b1, 8'h01},
            '{ROW_CFG,  REG_SPARE,         8'h5A, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, 8'h00, 8'h80, 1'b1, 1'b1, 8'h81},
            '{ROW_CFG,  REG_HEADER_FIRST,  8'hFF, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  REG_HEADER_SECOND, 8'hFF, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFD},
            // id only taken from the first byte of the frame
            '{ROW_BYTE, 8'h3C, 8'h12, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, 8'hC3, 8'h34, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, 8'h99, 8'h56, 1'b1, 1'b0, 8'h00},
            '{ROW_BYTE, 8'h55, 8'hAA, 1'b1, 1'b0, 8'h00},
            '{ROW_BYTE, 8'hAA, 8'h55, 1'b1, 1'b0, 8'h00},
            '{ROW_CFG,  REG_HEADER_FIRST,  8'h12, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  REG_HEADER_SECOND, 8'hED, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, 8'h01, 8'h7F, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, 8'h80, 8'h01, 1'b1, 1'b0, 8'h00}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].a, plan[i].b);
            else
                send_byte(plan[i].a, plan[i].b, plan[i].last, plan[i].has_sum, plan[i].sum);
        end

        sent   = 0;
        msg_no = 0;
        while (sent < RAND_BYTES) begin
            // open with a frame filled exactly to capacity, then one whose last byte is dropped
            if (msg_no == 0)
                len = CAP;
            else if (msg_no == 1)
                len = CAP + 1;
            else begin
                pick = $urandom_range(0, 15);
                if (pick < 10)
                    len = $urandom_range(1, 6);
                else if (pick < 14)
                    len = $urandom_range(7, CAP);
                else
                    len = $urandom_range(CAP + 1, CAP + 6);
            end
            if (msg_no % 8 == 7) begin
                write_reg(REG_HEADER_FIRST, 8'($urandom_range(0, 255)));
                write_reg(REG_HEADER_SECOND, 8'($urandom_range(0, 255)));
            end
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < len; k++)
                send_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          (k == len - 1), 1'b0, 8'h00);
            sent   += len;
            msg_no += 1;
        end

        wait_frames_out();
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin : frame_sink
        int unsigned stall;
        frame_beat_t want;
        @(posedge rst_n);
        forever begin
            stall = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do begin
                @(posedge clk);
            end while (!m_tvalid);
            if (pending_beats.size() == 0) begin
                $display("%0t: frame byte with none expected: expected none, actual %02h",
                         $time, m_tdata);
                error_count++;
            end
            else begin
                want = pending_beats.pop_front();
                if (m_tdata !== want.frame_byte) begin
                    $display("%0t: frame_byte expected %02h, actual %02h",
                             $time, want.frame_byte, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.frame_end) begin
                    $display("%0t: frame_end expected %0b, actual %0b",
                             $time, want.frame_end, m_tlast);
                    error_count++;
                end
                if (m_tuser !== want.overflow) begin
                    $display("%0t: overflow expected %0b, actual %0b",
                             $time, want.overflow, m_tuser);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #(5_000_000);
        $display("tb_top failed");
        $finish;
    end

endmodule

// ===== sum8_packet_framer_core.f =====
hw/rtl/s8pf_pkg.sv
hw/rtl/s8pf_payload_mem.sv
hw/rtl/s8pf_ctrl.sv
hw/rtl/sum8_packet_framer_core.sv
hw/rtl/s8pf_checker.sv
tb/tb_top.sv
